// ----- rtl/core/lsh_pkg.sv -----
`timescale 1ns / 1ps
// shared types, register codes and pipeline constants for the point light shader
// no dependencies; imported by lsh_unit, lsh_atten and the shader top level
package lsh_pkg;

  localparam int TEXEL_BITS = 8;
  localparam logic [TEXEL_BITS-1:0] TEXEL_MAX = '1;
  localparam int VEC_BITS = 16;

  // normalizer: magnitudes are shifted so the largest reaches bit NORM_MSB
  localparam int NORM_BITS      = 30;
  localparam int NORM_MSB       = 29;
  localparam int UNIT_ROOT_BITS = 31;
  localparam int QUOT_BITS      = 16;
  localparam int DIST_ROOT_BITS = 16;
  localparam int RADIUS_BITS    = 15;
  localparam logic [16:0] GAIN_ONE = 17'h10000;

  // stage counts, in cycles after the request is taken
  localparam int UNIT_LAT = 3 + UNIT_ROOT_BITS + QUOT_BITS + 1;
  localparam int ATT_LAT  = 3 + DIST_ROOT_BITS + QUOT_BITS + 1;
  localparam int MIX_IDX  = UNIT_LAT + 10;
  localparam int OUT_LAT  = UNIT_LAT + 14;

  // register map, word index paddr[4:2]
  localparam int PADDR_BITS = 5;
  localparam logic [2:0] REG_RADIUS         = 3'd0;
  localparam logic [2:0] REG_AMBIENT_FLOOR  = 3'd1;
  localparam logic [2:0] REG_SPECULAR_RED   = 3'd2;
  localparam logic [2:0] REG_SPECULAR_GREEN = 3'd3;
  localparam logic [2:0] REG_SPECULAR_BLUE  = 3'd4;

  localparam logic [14:0] RST_RADIUS         = 15'd11520;
  localparam logic [15:0] RST_AMBIENT_FLOOR  = 16'd16384;
  localparam logic [15:0] RST_SPECULAR_RED   = 16'd55706;
  localparam logic [15:0] RST_SPECULAR_GREEN = 16'd32768;
  localparam logic [15:0] RST_SPECULAR_BLUE  = 16'd0;

  // element 0 is x
  typedef logic [2:0][VEC_BITS-1:0] vec_t;
  typedef logic [2:0][16:0]         uvec_t;

  typedef struct packed {
    logic [23:0]        color_rgb;
    logic [23:0]        normal_texel;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic signed [15:0] light_to_point_x;
    logic signed [15:0] light_to_point_y;
    logic signed [15:0] light_to_point_z;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
  } shade_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } shade_out_t;

endpackage

// ----- rtl/core/lsh_delay.sv -----
`timescale 1ns / 1ps
// stallable shift line that keeps side data aligned with the pipeline
// uses no package items
module lsh_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

// ----- rtl/core/lsh_isqrt.sv -----
`timescale 1ns / 1ps
// pipelined floor square root, one root bit per stage
// uses no package items
module lsh_isqrt #(
  parameter int ROOT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2*ROOT_BITS-1:0] radicand,
  output logic [ROOT_BITS-1:0]   root
);

  localparam int RW = ROOT_BITS + 2;

  logic [2*ROOT_BITS-1:0] rad_q  [ROOT_BITS];
  logic [RW-1:0]          rem_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0]   root_q [ROOT_BITS];

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
    logic [2*ROOT_BITS-1:0] rad_in;
    logic [RW-1:0]          rem_in;
    logic [ROOT_BITS-1:0]   root_in;
    logic [RW-1:0]          rem_sh;
    logic [RW-1:0]          trial;
    logic                   fits;

    if (i == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // remainder stays below 2^ROOT_BITS at entry, so the top two bits are free
    assign rem_sh = {rem_in[RW-3:0], rad_in[2*ROOT_BITS-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i]  <= {rad_in[2*ROOT_BITS-3:0], 2'b00};
        rem_q[i]  <= fits ? rem_sh - trial : rem_sh;
        root_q[i] <= {root_in[ROOT_BITS-2:0], fits};
      end
    end
  end

  assign root = root_q[ROOT_BITS-1];

endmodule

// ----- rtl/core/lsh_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// uses no package items; start remainder must be below the divisor
module lsh_div #(
  parameter int DIV_BITS  = 16,
  parameter int QUOT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_BITS-1:0]  rem0,
  input  logic [QUOT_BITS-1:0] low,
  input  logic [DIV_BITS-1:0]  divisor,
  output logic [QUOT_BITS-1:0] quot
);

  logic [DIV_BITS-1:0]  rem_q  [QUOT_BITS];
  logic [QUOT_BITS-1:0] low_q  [QUOT_BITS];
  logic [DIV_BITS-1:0]  div_q  [QUOT_BITS];
  logic [QUOT_BITS-1:0] quot_q [QUOT_BITS];

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
    logic [DIV_BITS-1:0]  rem_in;
    logic [DIV_BITS-1:0]  div_in;
    logic [QUOT_BITS-1:0] low_in;
    logic [QUOT_BITS-1:0] quot_in;
    logic [DIV_BITS:0]    rem_sh;
    logic [DIV_BITS:0]    rem_sub;
    logic                 fits;

    if (i == 0) begin : g_first
      assign rem_in  = rem0;
      assign div_in  = divisor;
      assign low_in  = low;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign div_in  = div_q[i-1];
      assign low_in  = low_q[i-1];
      assign quot_in = quot_q[i-1];
    end

    assign rem_sh  = {rem_in, low_in[QUOT_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, div_in};
    assign fits    = rem_sh >= {1'b0, div_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= fits ? rem_sub[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
        low_q[i]  <= {low_in[QUOT_BITS-2:0], 1'b0};
        div_q[i]  <= div_in;
        quot_q[i] <= {quot_in[QUOT_BITS-2:0], fits};
      end
    end
  end

  assign quot = quot_q[QUOT_BITS-1];

endmodule

// ----- rtl/core/lsh_unit.sv -----
`timescale 1ns / 1ps
// vector normalizer: scale up, sum of squares, root, three divides, sign
// depends on lsh_pkg, lsh_delay, lsh_isqrt, lsh_div
module lsh_unit
  import lsh_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  vec_t  vec,
  output uvec_t dir
);

  logic [VEC_BITS-1:0]    mag [3];
  logic [VEC_BITS-1:0]    mx;
  logic [4:0]             msb;
  logic [4:0]             sh;
  logic [NORM_BITS-1:0]   ms_a [3];
  logic [3:0]             flags_a;
  logic [2*NORM_BITS-1:0] sq_b [3];
  logic [61:0]            len2_c;
  logic [UNIT_ROOT_BITS-1:0] len;
  logic [3*NORM_BITS-1:0] ms_d;
  logic [3:0]             flags_e;
  logic [QUOT_BITS-1:0]   quot [3];

  always_comb begin
    mx  = '0;
    msb = '0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = vec[k][VEC_BITS-1] ? VEC_BITS'(-vec[k]) : vec[k];
      if (mag[k] > mx) mx = mag[k];
    end
    for (int b = 0; b < VEC_BITS; b++) begin
      if (mx[b]) msb = 5'(b);
    end
    sh = 5'(NORM_MSB) - msb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ms_a[k]    <= NORM_BITS'(mag[k]) << sh;
        flags_a[k] <= vec[k][VEC_BITS-1];
      end
      flags_a[3] <= (mx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) sq_b[k] <= ms_a[k] * ms_a[k];
      len2_c <= 62'(sq_b[0]) + 62'(sq_b[1]) + 62'(sq_b[2]);
    end
  end

  lsh_isqrt #(.ROOT_BITS(UNIT_ROOT_BITS)) u_root (
    .clk(clk), .en(en), .radicand(len2_c), .root(len)
  );

  // scaled magnitudes wait for the root
  lsh_delay #(.WIDTH(3*NORM_BITS), .DEPTH(2 + UNIT_ROOT_BITS)) u_ms_dly (
    .clk(clk), .en(en), .d({ms_a[2], ms_a[1], ms_a[0]}), .q(ms_d)
  );

  // signs and zero flag wait for the quotients
  lsh_delay #(.WIDTH(4), .DEPTH(UNIT_LAT - 2)) u_flag_dly (
    .clk(clk), .en(en), .d(flags_a), .q(flags_e)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [NORM_BITS-1:0] ms_k;
    assign ms_k = ms_d[k*NORM_BITS +: NORM_BITS];

    // (ms << 15) / len, the magnitude never exceeds len
    lsh_div #(.DIV_BITS(UNIT_ROOT_BITS), .QUOT_BITS(QUOT_BITS)) u_div (
      .clk(clk), .en(en),
      .rem0(UNIT_ROOT_BITS'(ms_k[NORM_BITS-1:1])),
      .low({ms_k[0], {(QUOT_BITS-1){1'b0}}}),
      .divisor(len),
      .quot(quot[k])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        if (flags_e[3]) dir[k] <= '0;
        else if (flags_e[k]) dir[k] <= 17'(-{1'b0, quot[k]});
        else dir[k] <= {1'b0, quot[k]};
      end
    end
  end

endmodule

// ----- rtl/core/lsh_atten.sv -----
`timescale 1ns / 1ps
// distance attenuation: length of the light vector over the radius
// depends on lsh_pkg, lsh_delay, lsh_isqrt, lsh_div
module lsh_atten
  import lsh_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  vec_t                   vec,
  input  logic [RADIUS_BITS-1:0] radius,
  input  logic [15:0]            ambient,
  output logic [16:0]            att
);

  logic [VEC_BITS-1:0]       mag_a [3];
  logic [2*VEC_BITS-1:0]     sq_b [3];
  logic [2*VEC_BITS-1:0]     len2_c;
  logic [DIST_ROOT_BITS-1:0] dlen;
  logic [RADIUS_BITS-1:0]    rad;
  logic                      far;
  logic                      far_d;
  logic [QUOT_BITS-1:0]      ratio;
  logic [16:0]               att_raw;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag_a[k] <= vec[k][VEC_BITS-1] ? VEC_BITS'(-vec[k]) : vec[k];
        sq_b[k]  <= mag_a[k] * mag_a[k];
      end
      len2_c <= 32'(34'(sq_b[0]) + 34'(sq_b[1]) + 34'(sq_b[2]));
    end
  end

  lsh_isqrt #(.ROOT_BITS(DIST_ROOT_BITS)) u_root (
    .clk(clk), .en(en), .radicand(len2_c), .root(dlen)
  );

  // zero radius acts as one lsb; at or past the radius the ratio is at least one
  assign rad = (radius == '0) ? RADIUS_BITS'(1) : radius;
  assign far = dlen >= {1'b0, rad};

  lsh_div #(.DIV_BITS(RADIUS_BITS), .QUOT_BITS(QUOT_BITS)) u_div (
    .clk(clk), .en(en), .rem0(dlen[RADIUS_BITS-1:0]), .low('0),
    .divisor(rad), .quot(ratio)
  );

  lsh_delay #(.WIDTH(1), .DEPTH(QUOT_BITS)) u_far_dly (
    .clk(clk), .en(en), .d(far), .q(far_d)
  );

  assign att_raw = far_d ? '0 : GAIN_ONE - {1'b0, ratio};

  always_ff @(posedge clk) begin
    if (en) att <= (att_raw < {1'b0, ambient}) ? {1'b0, ambient} : att_raw;
  end

endmodule

// ----- rtl/core/normal_mapped_point_light_shade.sv -----
`timescale 1ns / 1ps
// top level of the normal-mapped point light shader: register port and lighting pipeline
// depends on lsh_pkg, lsh_delay, lsh_unit, lsh_atten
//
// Shades one fragment per clock while pixels are taken. A fragment request enters on frag
// and its lit pixel leaves on pixel; the pipeline takes a new request every cycle unless
// the output holds. Depth is set by the four vector normalizers, each a 31-stage square
// root followed by a 16-stage divider, plus the lighting math behind them. When a
// finished pixel is not taken the whole pipeline holds, frag_ready drops, and
// nothing is lost or repeated. Registers sit on an APB-style port at byte offsets
// 0x00 radius, 0x04 ambient floor, 0x08/0x0C/0x10 specular red/green/blue; write
// them only while no fragment is in flight.
module normal_mapped_point_light_shade
  import lsh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  frag_valid,
  output logic                  frag_ready,
  input  shade_in_t             frag,
  output logic                  pixel_valid,
  input  logic                  pixel_ready,
  output shade_out_t            pixel,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration registers
  logic [RADIUS_BITS-1:0] falloff_radius;
  logic [15:0]            ambient_floor;
  logic [15:0]            spec [3];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      falloff_radius <= RST_RADIUS;
      ambient_floor  <= RST_AMBIENT_FLOOR;
      spec[0]        <= RST_SPECULAR_RED;
      spec[1]        <= RST_SPECULAR_GREEN;
      spec[2]        <= RST_SPECULAR_BLUE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_RADIUS:         falloff_radius <= pwdata[RADIUS_BITS-1:0];
        REG_AMBIENT_FLOOR:  ambient_floor  <= pwdata[15:0];
        REG_SPECULAR_RED:   spec[0]        <= pwdata[15:0];
        REG_SPECULAR_GREEN: spec[1]        <= pwdata[15:0];
        REG_SPECULAR_BLUE:  spec[2]        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_RADIUS:         prdata = 32'(falloff_radius);
      REG_AMBIENT_FLOOR:  prdata = 32'(ambient_floor);
      REG_SPECULAR_RED:   prdata = 32'(spec[0]);
      REG_SPECULAR_GREEN: prdata = 32'(spec[1]);
      REG_SPECULAR_BLUE:  prdata = 32'(spec[2]);
      default:            prdata = '0;
    endcase
  end

  // pipeline control: every stage advances together unless the output pixel waits
  logic               en;
  logic [OUT_LAT-1:0] vld;

  assign en          = !vld[OUT_LAT-1] || pixel_ready;
  assign frag_ready  = en;
  assign pixel_valid = vld[OUT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[OUT_LAT-2:0], frag_valid};
  end

  // input vectors; the normal texel expands to 2t - max
  vec_t nrm_vec, ltp_vec, inc_vec, view_vec;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nrm_vec[k] = {{(VEC_BITS-TEXEL_BITS-1){1'b0}},
                    frag.normal_texel[(2-k)*TEXEL_BITS +: TEXEL_BITS], 1'b0}
                   - VEC_BITS'(TEXEL_MAX);
    end
    ltp_vec[0]  = frag.light_to_point_x;
    ltp_vec[1]  = frag.light_to_point_y;
    ltp_vec[2]  = frag.light_to_point_z;
    inc_vec[0]  = frag.light_x;
    inc_vec[1]  = frag.light_y;
    inc_vec[2]  = frag.light_z;
    view_vec[0] = frag.view_x;
    view_vec[1] = frag.view_y;
    view_vec[2] = frag.view_z;
  end

  // four normalizers in parallel, all ready at stage UNIT_LAT
  uvec_t nn, ld, ii, vv;

  lsh_unit u_norm (.clk(clk), .en(en), .vec(nrm_vec),  .dir(nn));
  lsh_unit u_ldir (.clk(clk), .en(en), .vec(ltp_vec),  .dir(ld));
  lsh_unit u_inc  (.clk(clk), .en(en), .vec(inc_vec),  .dir(ii));
  lsh_unit u_view (.clk(clk), .en(en), .vec(view_vec), .dir(vv));

  // attenuation from the light-to-point distance, ready at stage ATT_LAT
  logic [16:0] att, att_mix, att_fin;

  lsh_atten u_atten (
    .clk(clk), .en(en), .vec(ltp_vec), .radius(falloff_radius),
    .ambient(ambient_floor), .att(att)
  );

  lsh_delay #(.WIDTH(17), .DEPTH(MIX_IDX - ATT_LAT)) u_att_dly (
    .clk(clk), .en(en), .d(att), .q(att_mix)
  );

  lsh_delay #(.WIDTH(17), .DEPTH(2)) u_att_fin_dly (
    .clk(clk), .en(en), .d(att_mix), .q(att_fin)
  );

  // texel color rides along to the mixing stage
  logic [23:0] color_mix;

  lsh_delay #(.WIDTH(24), .DEPTH(MIX_IDX)) u_color_dly (
    .clk(clk), .en(en), .d(frag.color_rgb), .q(color_mix)
  );

  // dot products: light dir with normal, normal with incident
  logic signed [16:0] nn1 [3], ii1 [3], vv1 [3];
  logic signed [16:0] nn2 [3], ii2 [3], vv2 [3];
  logic signed [16:0] ii3 [3], vv3 [3], vv4 [3];
  logic signed [33:0] pln [3], pni [3];
  logic signed [34:0] dln, dni;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pln[k] <= $signed(ld[k]) * $signed(nn[k]);
        pni[k] <= $signed(nn[k]) * $signed(ii[k]);
        nn1[k] <= $signed(nn[k]);
        ii1[k] <= $signed(ii[k]);
        vv1[k] <= $signed(vv[k]);
        nn2[k] <= nn1[k];
        ii2[k] <= ii1[k];
        vv2[k] <= vv1[k];
      end
      dln <= pln[0] + pln[1] + pln[2];
      dni <= pni[0] + pni[1] + pni[2];
    end
  end

  // diffuse gain: dot / 2^14 truncated, clamped to 0..1.0
  logic [16:0] diff_n, diff, diff_mix;

  always_comb begin
    if (dln <= 0) diff_n = '0;
    else if (dln[34:14] > 21'(GAIN_ONE)) diff_n = GAIN_ONE;
    else diff_n = dln[30:14];
  end

  lsh_delay #(.WIDTH(17), .DEPTH(MIX_IDX - UNIT_LAT - 3)) u_diff_dly (
    .clk(clk), .en(en), .d(diff), .q(diff_mix)
  );

  // reflection r = i - round(dot(n,i) * n / 2^29)
  logic signed [51:0] pr [3];
  logic signed [51:0] pr_rnd [3];
  logic signed [22:0] rr [3];
  logic signed [39:0] pv [3];

  always_comb begin
    for (int k = 0; k < 3; k++) pr_rnd[k] = pr[k] + (52'sd1 <<< 28);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= diff_n;
      for (int k = 0; k < 3; k++) begin
        pr[k]  <= dni * nn2[k];
        ii3[k] <= ii2[k];
        vv3[k] <= vv2[k];
        rr[k]  <= 23'(ii3[k]) - $signed(pr_rnd[k][51:29]);
        vv4[k] <= vv3[k];
        pv[k]  <= vv4[k] * rr[k];
      end
    end
  end

  // specular: round(dot(v,r) / 2^14) clamped, then squared twice with rounding
  logic signed [41:0] vsum;
  logic signed [27:0] vdot;
  logic [16:0] s1_n, s1, s2, s4;
  logic [33:0] sq1, sq2, sq1_rnd, sq2_rnd;

  always_comb begin
    vsum = 42'(pv[0]) + 42'(pv[1]) + 42'(pv[2]) + 42'sd8192;
    vdot = vsum[41:14];
    if (vdot <= 0) s1_n = '0;
    else if (vdot > 28'sd65536) s1_n = GAIN_ONE;
    else s1_n = vdot[16:0];
    sq1_rnd = sq1 + 34'd32768;
    s2      = sq1_rnd[32:16];
    sq2_rnd = sq2 + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= s1_n;
      sq1 <= s1 * s1;
      sq2 <= s2 * s2;
      s4  <= sq2_rnd[32:16];
    end
  end

  // per-channel mix: c*att + c*diff + round(s4*spec*max / 2^17), then times att
  logic [32:0] sp [3];
  logic [41:0] st_n [3];
  logic [24:0] st [3], ca [3], cd [3];
  logic [26:0] csum [3];
  logic [43:0] prod [3];
  logic [44:0] lit [3];
  logic [7:0]  chan [3];
  logic [TEXEL_BITS-1:0] cval [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cval[k] = color_mix[(2-k)*TEXEL_BITS +: TEXEL_BITS];
      st_n[k] = {1'b0, sp[k], 8'b0} - 42'(sp[k]) + 42'h10000;
      lit[k]  = 45'(prod[k]) + 45'h80000000;
      chan[k] = (lit[k][44:32] > 13'(TEXEL_MAX)) ? TEXEL_MAX : lit[k][39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sp[k]   <= s4 * spec[k];
        st[k]   <= st_n[k][41:17];
        ca[k]   <= cval[k] * att_mix;
        cd[k]   <= cval[k] * diff_mix;
        csum[k] <= 27'(ca[k]) + 27'(cd[k]) + 27'(st[k]);
        prod[k] <= csum[k] * att_fin;
      end
      pixel.out_red   <= chan[0];
      pixel.out_green <= chan[1];
      pixel.out_blue  <= chan[2];
    end
  end

  // a waiting pixel must hold the whole pipeline
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |-> !frag_ready)
    else $error("request accepted while output pixel stalled");

  // every accepted request occupies the first stage
  a_request_enters: assert property (@(posedge clk) disable iff (rst)
    frag_valid && frag_ready |=> vld[0])
    else $error("accepted request missing from first stage");

  // a pixel only appears when the stage before it was occupied
  a_pixel_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(vld[OUT_LAT-2]))
    else $error("pixel valid without a request behind it");

endmodule

// ----- tb/tb_normal_mapped_point_light_shade.sv -----
`timescale 1ns / 1ps
// testbench for normal_mapped_point_light_shade: random and directed fragments, checked per pixel
// depends on lsh_pkg and the shader rtl; self-contained, no files or arguments
module tb_normal_mapped_point_light_shade;
  import lsh_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  frag_valid;
  logic                  frag_ready;
  shade_in_t             frag;
  logic                  pixel_valid;
  logic                  pixel_ready;
  shade_out_t            pixel;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  normal_mapped_point_light_shade dut (
    .clk(clk), .rst(rst),
    .frag_valid(frag_valid), .frag_ready(frag_ready), .frag(frag),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam longint TMAX      = 255;
  localparam int     STALL_MAX = 20000;

  // shadow copy of the shader registers
  logic [14:0] radius_q;
  logic [15:0] floor_q;
  logic [15:0] spec_q [3];

  // pixels still owed by the shader, oldest first
  class pixel_scoreboard;
    shade_out_t owed[$];
    int         errors;
    int         checked;

    function void note_request(shade_out_t exp);
      owed.push_back(exp);
    endfunction

    function void check_pixel(shade_out_t got);
      shade_out_t exp;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel %h", got);
        return;
      end
      exp = owed.pop_front();
      checked++;
      if (exp.out_red !== got.out_red || exp.out_green !== got.out_green ||
          exp.out_blue !== got.out_blue) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                   exp.out_red, exp.out_green, exp.out_blue,
                   got.out_red, got.out_green, got.out_blue);
      end
    endfunction
  endclass

  pixel_scoreboard sb;
  int tx_idle;
  int rx_idle;
  int stall_cnt;
  int sent;

  // floor square root, bit by bit
  function automatic longint floor_sqrt(longint n);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // round to nearest, ties up; equals floor((v + half) / 2^s)
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // unit vector scaled by 2^15; zero vector stays zero
  function automatic void unit_vec(input longint x[3], output longint q[3]);
    longint m[3];
    longint mx;
    longint len2;
    longint len;
    int     s;
    mx = 0;
    len2 = 0;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = x[k] < 0 ? -x[k] : x[k];
      if (m[k] > mx) mx = m[k];
    end
    if (mx == 0) begin
      for (int k = 0; k < 3; k++) q[k] = 0;
      return;
    end
    while ((mx <<< s) < (64'sd1 <<< 29)) s++;
    for (int k = 0; k < 3; k++) begin
      m[k] = m[k] <<< s;
      len2 += m[k] * m[k];
    end
    len = floor_sqrt(len2);
    for (int k = 0; k < 3; k++) q[k] = x[k] < 0 ? -((m[k] <<< 15) / len) : (m[k] <<< 15) / len;
  endfunction

  // expected lit pixel for one fragment under the current registers
  function automatic shade_out_t shade_predict(shade_in_t f);
    longint nv[3], lv[3], pv[3], vw[3], col[3];
    longint nn[3], ld[3], ii[3], vv[3], rr[3];
    longint len2, dlen, rad, ratio, att, diff, s1, s2, s4, d, dni, sum, o;
    shade_out_t res;
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      col[k] = f.color_rgb[23 - 8*k -: 8];
      nv[k]  = 2 * longint'(f.normal_texel[23 - 8*k -: 8]) - TMAX;
    end
    lv = '{longint'(f.light_x), longint'(f.light_y), longint'(f.light_z)};
    pv = '{longint'(f.light_to_point_x), longint'(f.light_to_point_y),
           longint'(f.light_to_point_z)};
    vw = '{longint'(f.view_x), longint'(f.view_y), longint'(f.view_z)};
    unit_vec(nv, nn);
    unit_vec(pv, ld);
    unit_vec(lv, ii);
    unit_vec(vw, vv);
    for (int k = 0; k < 3; k++) len2 += pv[k] * pv[k];
    dlen = floor_sqrt(len2);
    // radius zero behaves as one lsb
    rad = radius_q == 0 ? 1 : longint'(radius_q);
    ratio = (dlen <<< 16) / rad;
    att = ratio >= 65536 ? 0 : 65536 - ratio;
    if (att < longint'(floor_q)) att = floor_q;
    d = ld[0]*nn[0] + ld[1]*nn[1] + ld[2]*nn[2];
    diff = d <= 0 ? 0 : d >>> 14;
    if (diff > 65536) diff = 65536;
    // reflect the first light vector about the normal
    dni = nn[0]*ii[0] + nn[1]*ii[1] + nn[2]*ii[2];
    for (int k = 0; k < 3; k++) rr[k] = ii[k] - round_shift(dni * nn[k], 29);
    d = round_shift(vv[0]*rr[0] + vv[1]*rr[1] + vv[2]*rr[2], 14);
    s1 = d <= 0 ? 0 : d;
    if (s1 > 65536) s1 = 65536;
    s2 = (s1 * s1 + 32768) >>> 16;
    s4 = (s2 * s2 + 32768) >>> 16;
    for (int k = 0; k < 3; k++) begin
      sum = col[k]*att + col[k]*diff + ((s4 * longint'(spec_q[k]) * TMAX + 65536) >>> 17);
      o = (sum * att + 64'sh80000000) >>> 32;
      if (o > TMAX) o = TMAX;
      if (k == 0) res.out_red = o[7:0];
      else if (k == 1) res.out_green = o[7:0];
      else res.out_blue = o[7:0];
    end
    return res;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, pixel check at each taken pixel
  always @(posedge clk) begin
    if (rst) begin
      pixel_ready <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) sb.check_pixel(pixel);
      pixel_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if (rst || (frag_valid && frag_ready) || (pixel_valid && pixel_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("watchdog expired with %0d pixels owed", sb.owed.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // apb write: setup then access, register taken on the access edge
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_BITS'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RADIUS:         radius_q  = val[14:0];
      REG_AMBIENT_FLOOR:  floor_q   = val[15:0];
      REG_SPECULAR_RED:   spec_q[0] = val[15:0];
      REG_SPECULAR_GREEN: spec_q[1] = val[15:0];
      REG_SPECULAR_BLUE:  spec_q[2] = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [14:0] r, logic [15:0] fl, logic [15:0] sr, logic [15:0] sg,
                           logic [15:0] sbl);
    write_reg(REG_RADIUS, 32'(r));
    write_reg(REG_AMBIENT_FLOOR, 32'(fl));
    write_reg(REG_SPECULAR_RED, 32'(sr));
    write_reg(REG_SPECULAR_GREEN, 32'(sg));
    write_reg(REG_SPECULAR_BLUE, 32'(sbl));
  endtask

  // hold off until every owed pixel is out and the pipe has emptied
  task automatic drain_pipe();
    frag_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (OUT_LAT + 20) @(posedge clk);
  endtask

  // one fragment request; valid stays up across back-to-back requests
  task automatic send_frag(shade_in_t f);
    if ($urandom_range(99) < tx_idle) begin
      frag_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    frag_valid <= 1'b1;
    frag       <= f;
    @(posedge clk);
    while (!frag_ready) @(posedge clk);
    sb.note_request(shade_predict(f));
    sent++;
  endtask

  function automatic logic [15:0] rand_vec(int r);
    return 16'($signed($urandom_range(0, 2*r)) - r);
  endfunction

  // mostly fragments in light range, some full-range noise
  function automatic shade_in_t rand_frag();
    shade_in_t f;
    int r;
    f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = radius_q / 2 + 1;
    if ($urandom_range(9) >= 2) begin
      f.light_x = rand_vec(4096);
      f.light_y = rand_vec(4096);
      f.light_z = rand_vec(4096);
      f.light_to_point_x = rand_vec(r);
      f.light_to_point_y = rand_vec(r);
      f.light_to_point_z = rand_vec(r);
      f.view_x = rand_vec(2048);
      f.view_y = rand_vec(2048);
      f.view_z = rand_vec(2048);
    end
    return f;
  endfunction

  task automatic directed_frags();
    shade_in_t f;
    for (int i = 0; i < 18; i++) begin
      f = '0;
      case (i)
        0: ;                                        // all zero vectors
        1: f = '1;                                  // all ones
        2: f = {24'hffffff, 24'h8080ff, 16'sh0000, 16'sh0000, 16'sh0100,
                16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0100};
        3: f = {24'hffffff, 24'h8080ff, 16'sh0000, 16'sh0000, 16'shff00,
                16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0100};
        4: f = {24'hffffff, 24'h000000, {9{16'sh8000}}};
        5: f = {24'h000000, 24'hffffff, {9{16'sh7fff}}};
        6: f = {24'hff00ff, 24'h7f7f7f, 16'sh7fff, 16'sh8000, 16'sh7fff,
                16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 16'sh0001};
        7: f = {24'h123456, 24'h80ff80, 16'sh0000, 16'sh0100, 16'sh0000,
                16'sh0000, 16'sh0200, 16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000};
        8: f = {24'hffffff, 24'hff8080, 16'shff00, 16'sh0000, 16'sh0000,
                16'sh2d00, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
        9: f = {24'haaaaaa, 24'h555555, 16'sh0001, 16'sh0001, 16'sh0001,
                16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001};
        default: f = rand_frag();
      endcase
      send_frag(f);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    frag_valid = 1'b0;
    frag = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    radius_q = RST_RADIUS;
    floor_q = RST_AMBIENT_FLOOR;
    spec_q = '{RST_SPECULAR_RED, RST_SPECULAR_GREEN, RST_SPECULAR_BLUE};
    tx_idle = 15;
    rx_idle = 49;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values first
    directed_frags();
    for (int p = 0; p < 6; p++) begin
      drain_pipe();
      case (p)
        0: load_regs(15'd32767, 16'd0, 16'hffff, 16'hffff, 16'hffff);
        1: load_regs(15'd1, 16'hffff, 16'd0, 16'd0, 16'd0);
        2: load_regs(15'd0, 16'd0, 16'h8000, 16'h0001, 16'hffff);
        3: load_regs(15'd11520, 16'd16384, 16'd55706, 16'd32768, 16'd0);
        default: load_regs(15'($urandom_range(1, 32767)), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
      endcase
      if (p < 3) directed_frags();
      for (int i = 0; i < 270; i++) begin
        // idling mode follows overall progress
        if (sent > 1150) begin
          tx_idle = 0;
          rx_idle = 0;
        end else if (sent > 580) begin
          tx_idle = 49;
          rx_idle = 15;
        end
        send_frag(rand_frag());
      end
    end

    frag_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (OUT_LAT + 20) @(posedge clk);
    $display("%0d fragments shaded and %0d pixels checked over six register settings",
             sent, sb.checked);
    $display("register extremes, zero radius, zero and full-scale vectors exercised");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lsh_pkg.sv
rtl/core/lsh_delay.sv
rtl/core/lsh_isqrt.sv
rtl/core/lsh_div.sv
rtl/core/lsh_unit.sv
rtl/core/lsh_atten.sv
rtl/core/normal_mapped_point_light_shade.sv
tb/tb_normal_mapped_point_light_shade.sv
